FILE: rtl/line_printer_control_decoder_top_macros.svh
// Assertion macros shared by the files that check their own logic.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef LINE_PRINTER_CONTROL_DECODER_TOP_MACROS_SVH
`define LINE_PRINTER_CONTROL_DECODER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPCD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LPCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/lpcd_pkg.sv
`timescale 1ns / 1ps

package lpcd_pkg;

  localparam int TAB_STOP_DEF    = 8;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int LINE_W          = 8;

  localparam logic [7:0] LINE_MAX_RST = 8'd80;
  localparam logic [7:0] PAGE_LEN_RST = 8'd66;

  localparam logic [6:0] CODE_TAB  = 7'h09;
  localparam logic [6:0] CODE_LF   = 7'h0A;
  localparam logic [6:0] CODE_FF   = 7'h0C;
  localparam logic [6:0] CODE_CR   = 7'h0D;
  localparam logic [6:0] PRINT_MIN = 7'd32;

  typedef enum logic [1:0] {
    CFG_LINE_MAX    = 2'd0,
    CFG_PAGE_LEN    = 2'd1,
    CFG_DIRECT_MODE = 2'd2,
    CFG_PRINT_AS_GO = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    KIND_IGNORE  = 3'd0,
    KIND_CHAR    = 3'd1,
    KIND_SPACES  = 3'd2,
    KIND_ADVANCE = 3'd3,
    KIND_RAW     = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    OP_IGNORE,
    OP_PRINT,
    OP_TAB,
    OP_CR,
    OP_LF,
    OP_FF,
    OP_RAW
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [6:0] ch;
  } item_t;

  typedef struct packed {
    logic [7:0] line_max;
    logic [7:0] page_len;
    logic       direct_mode;
    logic       print_as_go;
  } cfg_t;

  typedef struct packed {
    kind_e      kind;
    logic [6:0] ch;
    logic [3:0] spaces;
    logic [8:0] lines;
    logic [1:0] pages;
    logic [7:0] column;
  } res_t;

endpackage

FILE: rtl/lpcd_rem.sv
`timescale 1ns / 1ps

module lpcd_rem (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [lpcd_pkg::LINE_W-1:0]  dividend_i,
  input  logic [lpcd_pkg::LINE_W-1:0]  divisor_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic [lpcd_pkg::LINE_W-1:0]  rem_o
);
  import lpcd_pkg::*;

  localparam int CNT_W = $clog2(LINE_W);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [LINE_W-1:0] dvd_q;
  logic [LINE_W-1:0] div_q;
  logic [LINE_W-1:0] rem_q;
  logic [LINE_W-1:0] rem_d;
  logic [LINE_W:0]   trial;

  // One restoring step per cycle, most significant dividend bit first.
  always_comb begin
    trial = {rem_q, dvd_q[LINE_W-1]};
    if (trial >= {1'b0, div_q}) begin
      rem_d = LINE_W'(trial - {1'b0, div_q});
    end else begin
      rem_d = trial[LINE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(LINE_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[LINE_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

FILE: rtl/lpcd_front.sv
`timescale 1ns / 1ps

module lpcd_front (
  input  logic            in_valid_i,
  input  logic [7:0]      char_in_i,
  input  logic            direct_mode_i,
  input  logic            full_i,
  output logic            in_stall_o,
  output logic            push_o,
  output lpcd_pkg::item_t item_o
);
  import lpcd_pkg::*;

  logic [6:0] code;

  assign code = char_in_i[6:0];

  always_comb begin
    item_o.ch = code;
    if (direct_mode_i) begin
      item_o.op = OP_RAW;
    end else begin
      case (code)
        CODE_TAB: item_o.op = OP_TAB;
        CODE_LF:  item_o.op = OP_LF;
        CODE_FF:  item_o.op = OP_FF;
        CODE_CR:  item_o.op = OP_CR;
        default: begin
          item_o.op = (code >= PRINT_MIN) ? OP_PRINT : OP_IGNORE;
        end
      endcase
    end
  end

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

FILE: rtl/lpcd_fifo.sv
`timescale 1ns / 1ps

module lpcd_fifo #(
  parameter int DEPTH = lpcd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lpcd_pkg::item_t item_i,
  input  logic            pop_i,
  output lpcd_pkg::item_t item_o,
  output logic            empty_o,
  output logic            full_o
);
  import lpcd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t             mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q;
  logic [PTR_W-1:0]  rd_ptr_q;
  logic [CNT_W-1:0]  count_q;
  logic              do_push;
  logic              do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

FILE: rtl/lpcd_back.sv
`timescale 1ns / 1ps

module lpcd_back #(
  parameter int TAB_STOP = lpcd_pkg::TAB_STOP_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lpcd_pkg::cfg_t  cfg_i,
  input  logic            reduce_start_i,
  input  lpcd_pkg::item_t item_i,
  input  logic            empty_i,
  input  logic            out_stall_i,
  output logic            pop_o,
  output logic            out_valid_o,
  output lpcd_pkg::res_t  res_o
);
  import lpcd_pkg::*;

  localparam int MW = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;

  logic [7:0]    column_q, column_d;
  logic [MW-1:0] col_mod_q, col_mod_d;
  logic [7:0]    line_q, line_d;
  logic [7:0]    line_raw_q, line_raw_d;
  logic          out_valid_q;
  res_t          res_q, res_d;

  logic          rem_busy;
  logic          rem_done;
  logic [7:0]    rem_val;
  logic          busy;

  logic [7:0]    plen;
  logic [8:0]    plen9;
  logic          first;
  logic          has_room;
  logic [7:0]    room;
  logic [7:0]    n_full;
  logic [7:0]    n_tab;
  logic [8:0]    lines;
  logic [8:0]    total;
  logic          ge1;
  logic          ge2;
  logic [8:0]    line_rem;

  // The raw line count is kept as last set by a line advance; line_q holds it
  // folded into the current page length.
  lpcd_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (reduce_start_i),
    .dividend_i (line_raw_q),
    .divisor_i  (plen),
    .busy_o     (rem_busy),
    .done_o     (rem_done),
    .rem_o      (rem_val)
  );

  assign busy  = reduce_start_i || rem_busy || rem_done;
  assign pop_o = !empty_i && !busy && (!out_valid_q || !out_stall_i);

  always_comb begin
    plen     = (cfg_i.page_len == '0) ? 8'd1 : cfg_i.page_len;
    plen9    = {1'b0, plen};
    first    = (column_q != '0);
    has_room = (column_q < cfg_i.line_max);
    room     = cfg_i.line_max - column_q;
    n_full   = 8'(TAB_STOP) - 8'(col_mod_q);
    n_tab    = (n_full > room) ? room : n_full;

    case (item_i.op)
      OP_CR:   lines = 9'd1;
      OP_LF:   lines = 9'd1 + 9'(first);
      OP_FF: begin
        if (first && (line_q == plen - 8'd1)) begin
          lines = plen9 + 9'd1;
        end else begin
          lines = plen9 - {1'b0, line_q};
        end
      end
      default: lines = '0;
    endcase

    // The line counter is kept below the page length, so at most two pages end here.
    total = {1'b0, line_q} + lines;
    ge2   = (total >= {plen, 1'b0});
    ge1   = (total >= plen9);
    if (ge2) begin
      line_rem = total - {plen, 1'b0};
    end else if (ge1) begin
      line_rem = total - plen9;
    end else begin
      line_rem = total;
    end

    column_d    = column_q;
    col_mod_d   = col_mod_q;
    line_d      = line_q;
    line_raw_d  = line_raw_q;
    res_d       = '0;
    res_d.kind  = KIND_IGNORE;

    case (item_i.op)
      OP_RAW: begin
        res_d.kind = KIND_RAW;
        res_d.ch   = item_i.ch;
      end
      OP_TAB: begin
        res_d.kind = KIND_SPACES;
        if (has_room) begin
          res_d.spaces = n_tab[3:0];
          column_d     = column_q + n_tab;
          col_mod_d    = (n_tab == n_full) ? '0 : col_mod_q + n_tab[MW-1:0];
        end
      end
      OP_CR, OP_LF, OP_FF: begin
        res_d.kind  = KIND_ADVANCE;
        res_d.lines = lines;
        res_d.pages = cfg_i.print_as_go ? {ge2, ge1 && !ge2} : 2'b00;
        line_d      = line_rem[7:0];
        line_raw_d  = line_rem[7:0];
        column_d    = '0;
        col_mod_d   = '0;
      end
      OP_PRINT: begin
        if (has_room) begin
          res_d.kind = KIND_CHAR;
          res_d.ch   = item_i.ch;
          column_d   = column_q + 8'd1;
          col_mod_d  = (col_mod_q == MW'(TAB_STOP - 1)) ? '0 : col_mod_q + 1'b1;
        end
      end
      default: begin
        res_d.kind = KIND_IGNORE;
      end
    endcase
    res_d.column = column_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q    <= '0;
      col_mod_q   <= '0;
      line_q      <= '0;
      line_raw_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (rem_done) begin
        line_q <= rem_val;
      end else if (pop_o) begin
        line_q <= line_d;
      end
      if (pop_o) begin
        column_q    <= column_d;
        col_mod_q   <= col_mod_d;
        line_raw_q  <= line_raw_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

FILE: rtl/line_printer_control_decoder_top.sv
// The queue and the output register decouple both sides; an accepted byte passes through both.
// Throughput: one byte per cycle while out_stall_i is low and no page length reduction runs.
// A page length write holds the back part while an 8-step remainder
// unit folds the line counter into the new page length.
// Reset is asynchronous and active low: line_max 80, page length 66, both modes off,
// column and line counters zero, queue and output register empty.
`timescale 1ns / 1ps

module line_printer_control_decoder_top #(
  parameter int TAB_STOP    = lpcd_pkg::TAB_STOP_DEF,
  parameter int QUEUE_DEPTH = lpcd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] kind_o,
  output logic [6:0] char_out_o,
  output logic [3:0] space_count_o,
  output logic [8:0] lines_advanced_o,
  output logic [1:0] pages_completed_o,
  output logic [7:0] column_after_o
);
  import lpcd_pkg::*;

  `include "line_printer_control_decoder_top_macros.svh"

  cfg_t  cfg_q;
  logic  reduce_q;
  logic  push;
  logic  pop;
  logic  empty;
  logic  full;
  item_t front_item;
  item_t queue_item;
  res_t  res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_max    <= LINE_MAX_RST;
      cfg_q.page_len    <= PAGE_LEN_RST;
      cfg_q.direct_mode <= 1'b0;
      cfg_q.print_as_go <= 1'b0;
      reduce_q          <= 1'b0;
    end else begin
      reduce_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LINE_MAX:    cfg_q.line_max <= cfg_data_i;
          CFG_PAGE_LEN: begin
            cfg_q.page_len <= cfg_data_i;
            reduce_q       <= 1'b1;
          end
          CFG_DIRECT_MODE: cfg_q.direct_mode <= cfg_data_i[0];
          CFG_PRINT_AS_GO: cfg_q.print_as_go <= cfg_data_i[0];
          default: begin
            reduce_q <= 1'b0;
          end
        endcase
      end
    end
  end

  lpcd_front u_front (
    .in_valid_i    (in_valid_i),
    .char_in_i     (char_in_i),
    .direct_mode_i (cfg_q.direct_mode),
    .full_i        (full),
    .in_stall_o    (in_stall_o),
    .push_o        (push),
    .item_o        (front_item)
  );

  lpcd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .item_o  (queue_item),
    .empty_o (empty),
    .full_o  (full)
  );

  lpcd_back #(
    .TAB_STOP (TAB_STOP)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .reduce_start_i (reduce_q),
    .item_i         (queue_item),
    .empty_i        (empty),
    .out_stall_i    (out_stall_i),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .res_o          (res)
  );

  assign kind_o            = res.kind;
  assign char_out_o        = res.ch;
  assign space_count_o     = res.spaces;
  assign lines_advanced_o  = res.lines;
  assign pages_completed_o = res.pages;
  assign column_after_o    = res.column;

  `LPCD_ASSERT_SAME(a_advance_clears_column,
    out_valid_o && (kind_o == KIND_ADVANCE), column_after_o == '0,
    "line advance left characters on the line")
  `LPCD_ASSERT_SAME(a_pages_only_on_advance,
    out_valid_o && (pages_completed_o != '0),
    (kind_o == KIND_ADVANCE) && cfg_q.print_as_go,
    "page completion reported outside a line advance in print-as-go mode")
  `LPCD_ASSERT_SAME(a_raw_has_no_format,
    out_valid_o && (kind_o == KIND_RAW),
    (lines_advanced_o == '0) && (space_count_o == '0) && (pages_completed_o == '0),
    "raw beat carries formatting counts")
  `LPCD_ASSERT_NEXT(a_no_pop_while_reducing,
    reduce_q, !pop,
    "queue popped while the line counter was being reduced")

endmodule
